### design/snrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snrt_pkg
// Shared types and codes for the sorted name record table.
// ----------------------------------------------------------------------------
package snrt_pkg;

    localparam int KEY_HIGH_W   = 16;
    localparam int KEY_LOW_W    = 64;
    localparam int VALUE_HIGH_W = 32;
    localparam int VALUE_MID_W  = 64;
    localparam int VALUE_LOW_W  = 64;
    localparam int KEY_W        = KEY_HIGH_W + KEY_LOW_W;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_SEARCH = 2'd2,
        KIND_DUMP   = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_INSERTED   = 4'd0,
        ST_DUPLICATE  = 4'd1,
        ST_FULL       = 4'd2,
        ST_DELETED    = 4'd3,
        ST_EMPTY      = 4'd4,
        ST_MISSING    = 4'd5,
        ST_FOUND      = 4'd6,
        ST_DUMP_ENTRY = 4'd7,
        ST_DUMP_EMPTY = 4'd8
    } status_t;

    typedef struct packed {
        logic [KEY_HIGH_W-1:0]   key_high;
        logic [KEY_LOW_W-1:0]    key_low;
        logic [VALUE_HIGH_W-1:0] value_high;
        logic [VALUE_MID_W-1:0]  value_mid;
        logic [VALUE_LOW_W-1:0]  value_low;
    } rec_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC,
        IDX_COUNT
    } idx_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_PREV,
        RD_NEXT
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_REQ,
        WR_RD
    } wr_op_t;

    // Output payload source
    typedef enum logic [1:0] {
        SRC_REQ_ZERO,   // request key, zero value
        SRC_REQ_HIT,    // request key, value of the record just read
        SRC_REC,        // record just read
        SRC_ZERO        // all zero
    } out_src_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_WALK,
        S_CMP,
        S_ISHIFT,
        S_IWRITE,
        S_DSHIFT,
        S_DWRITE
    } state_t;

    typedef struct packed {
        logic     load_req;
        idx_op_t  idx_op;
        logic     set_pos;
        cnt_op_t  cnt_op;
        logic     mem_rd;
        rd_sel_t  rd_sel;
        wr_op_t   wr_op;
        logic     out_load;
        status_t  out_status;
        out_src_t out_src;
        logic     out_last;
    } dp_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  at_end;      // index reached record count
        logic  empty;
        logic  full;
        logic  idx_gt_pos;
        logic  next_in;     // index + 1 below record count
        logic  last_entry;  // index + 1 equals record count
        logic  key_eq;
        logic  key_gt;      // stored key above request key
        logic  out_free;
    } dp_sts_t;

endpackage

### design/snrt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snrt_dp
// Datapath: request register, record memory, index/count, output register.
// ----------------------------------------------------------------------------
module snrt_dp #(
    parameter int ENTRIES = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  snrt_pkg::dp_cmd_t                   cmd,
    output snrt_pkg::dp_sts_t                   sts,
    input  logic [1:0]                          kind,
    input  logic [snrt_pkg::KEY_HIGH_W-1:0]     key_high,
    input  logic [snrt_pkg::KEY_LOW_W-1:0]      key_low,
    input  logic [snrt_pkg::VALUE_HIGH_W-1:0]   value_high,
    input  logic [snrt_pkg::VALUE_MID_W-1:0]    value_mid,
    input  logic [snrt_pkg::VALUE_LOW_W-1:0]    value_low,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [3:0]                          status,
    output logic [snrt_pkg::KEY_HIGH_W-1:0]     out_key_high,
    output logic [snrt_pkg::KEY_LOW_W-1:0]      out_key_low,
    output logic [snrt_pkg::VALUE_HIGH_W-1:0]   out_value_high,
    output logic [snrt_pkg::VALUE_MID_W-1:0]    out_value_mid,
    output logic [snrt_pkg::VALUE_LOW_W-1:0]    out_value_low,
    output logic                                last
);

    localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);

    snrt_pkg::rec_t  mem [ENTRIES];
    snrt_pkg::rec_t  req_reg;
    snrt_pkg::kind_t kind_reg;
    snrt_pkg::rec_t  rd_reg;
    snrt_pkg::rec_t  out_reg;
    snrt_pkg::rec_t  out_next;
    logic [3:0]      status_reg;
    logic            last_reg;
    logic            out_valid_reg;

    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  pos_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_prev, idx_succ;
    logic [CNT_W:0]    idx_plus1;
    logic [ADDR_W-1:0] rd_addr;
    logic [snrt_pkg::KEY_W-1:0] req_key, rd_key;

    assign idx_prev  = idx_reg - CNT_W'(1);
    assign idx_succ  = idx_reg + CNT_W'(1);
    assign idx_plus1 = {1'b0, idx_reg} + (CNT_W+1)'(1);
    assign req_key   = {req_reg.key_high, req_reg.key_low};
    assign rd_key    = {rd_reg.key_high, rd_reg.key_low};

    // status to controller
    always_comb
    begin
        sts.kind       = kind_reg;
        sts.at_end     = (idx_reg == count_reg);
        sts.empty      = (count_reg == '0);
        sts.full       = (count_reg == CNT_W'(ENTRIES));
        sts.idx_gt_pos = (idx_reg > pos_reg);
        sts.next_in    = (idx_plus1 < {1'b0, count_reg});
        sts.last_entry = (idx_plus1 == {1'b0, count_reg});
        sts.key_eq     = (rd_key == req_key);
        sts.key_gt     = (rd_key > req_key);
        sts.out_free   = !out_valid_reg || !out_stall;
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            kind_reg           <= snrt_pkg::kind_t'(kind);
            req_reg.key_high   <= key_high;
            req_reg.key_low    <= key_low;
            req_reg.value_high <= value_high;
            req_reg.value_mid  <= value_mid;
            req_reg.value_low  <= value_low;
        end
    end

    // index and count
    always_comb
    begin
        case (cmd.idx_op)
            snrt_pkg::IDX_ZERO:  idx_next = '0;
            snrt_pkg::IDX_INC:   idx_next = idx_succ;
            snrt_pkg::IDX_DEC:   idx_next = idx_prev;
            snrt_pkg::IDX_COUNT: idx_next = count_reg;
            default:             idx_next = idx_reg;
        endcase
        case (cmd.cnt_op)
            snrt_pkg::CNT_INC: count_next = count_reg + CNT_W'(1);
            snrt_pkg::CNT_DEC: count_next = count_reg - CNT_W'(1);
            default:           count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            pos_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            idx_reg   <= idx_next;
            count_reg <= count_next;
            if (cmd.set_pos)
                pos_reg <= idx_reg;
        end
    end

    // record memory: one read, one write port
    always_comb
    begin
        case (cmd.rd_sel)
            snrt_pkg::RD_PREV: rd_addr = idx_prev[ADDR_W-1:0];
            snrt_pkg::RD_NEXT: rd_addr = idx_succ[ADDR_W-1:0];
            default:           rd_addr = idx_reg[ADDR_W-1:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_rd)
            rd_reg <= mem[rd_addr];
        if (cmd.wr_op == snrt_pkg::WR_REQ)
            mem[idx_reg[ADDR_W-1:0]] <= req_reg;
        else if (cmd.wr_op == snrt_pkg::WR_RD)
            mem[idx_reg[ADDR_W-1:0]] <= rd_reg;
    end

    // output register
    always_comb
    begin
        out_next = '0;
        case (cmd.out_src)
            snrt_pkg::SRC_REQ_ZERO:
            begin
                out_next.key_high = req_reg.key_high;
                out_next.key_low  = req_reg.key_low;
            end
            snrt_pkg::SRC_REQ_HIT:
            begin
                out_next          = rd_reg;
                out_next.key_high = req_reg.key_high;
                out_next.key_low  = req_reg.key_low;
            end
            snrt_pkg::SRC_REC: out_next = rd_reg;
            default:           out_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg    <= out_next;
            status_reg <= cmd.out_status;
            last_reg   <= cmd.out_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign out_key_high   = out_reg.key_high;
    assign out_key_low    = out_reg.key_low;
    assign out_value_high = out_reg.value_high;
    assign out_value_mid  = out_reg.value_mid;
    assign out_value_low  = out_reg.value_low;
    assign last           = last_reg;

endmodule

### design/snrt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snrt_ctrl
// Controller: sequences walk, shift and output steps of one transaction.
// ----------------------------------------------------------------------------
module snrt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  snrt_pkg::dp_sts_t sts,
    output snrt_pkg::dp_cmd_t cmd
);

    snrt_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= snrt_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        in_stall       = (state_reg != snrt_pkg::S_IDLE);
        cmd            = '0;
        cmd.idx_op     = snrt_pkg::IDX_HOLD;
        cmd.cnt_op     = snrt_pkg::CNT_HOLD;
        cmd.rd_sel     = snrt_pkg::RD_IDX;
        cmd.wr_op      = snrt_pkg::WR_NONE;
        cmd.out_status = snrt_pkg::ST_INSERTED;
        cmd.out_src    = snrt_pkg::SRC_REQ_ZERO;
        cmd.out_last   = 1'b1;

        case (state_reg)
            snrt_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    cmd.idx_op   = snrt_pkg::IDX_ZERO;
                    state_next   = snrt_pkg::S_START;
                end
            end

            snrt_pkg::S_START:
            begin
                if (sts.empty && sts.kind == snrt_pkg::KIND_DELETE)
                begin
                    cmd.out_load   = sts.out_free;
                    cmd.out_status = snrt_pkg::ST_EMPTY;
                    if (sts.out_free)
                        state_next = snrt_pkg::S_IDLE;
                end
                else if (sts.empty && sts.kind == snrt_pkg::KIND_DUMP)
                begin
                    cmd.out_load   = sts.out_free;
                    cmd.out_status = snrt_pkg::ST_DUMP_EMPTY;
                    cmd.out_src    = snrt_pkg::SRC_ZERO;
                    if (sts.out_free)
                        state_next = snrt_pkg::S_IDLE;
                end
                else
                    state_next = snrt_pkg::S_WALK;
            end

            snrt_pkg::S_WALK:
            begin
                if (!sts.at_end)
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = snrt_pkg::S_CMP;
                end
                else
                begin
                    case (sts.kind)
                        snrt_pkg::KIND_INSERT:
                        begin
                            if (sts.full)
                            begin
                                cmd.out_load   = sts.out_free;
                                cmd.out_status = snrt_pkg::ST_FULL;
                                if (sts.out_free)
                                    state_next = snrt_pkg::S_IDLE;
                            end
                            else
                            begin
                                cmd.set_pos = 1'b1;
                                state_next  = snrt_pkg::S_ISHIFT;
                            end
                        end
                        snrt_pkg::KIND_DELETE, snrt_pkg::KIND_SEARCH:
                        begin
                            cmd.out_load   = sts.out_free;
                            cmd.out_status = snrt_pkg::ST_MISSING;
                            if (sts.out_free)
                                state_next = snrt_pkg::S_IDLE;
                        end
                        default: state_next = snrt_pkg::S_IDLE;
                    endcase
                end
            end

            snrt_pkg::S_CMP:
            begin
                case (sts.kind)
                    snrt_pkg::KIND_DUMP:
                    begin
                        cmd.out_load   = sts.out_free;
                        cmd.out_status = snrt_pkg::ST_DUMP_ENTRY;
                        cmd.out_src    = snrt_pkg::SRC_REC;
                        cmd.out_last   = sts.last_entry;
                        if (sts.out_free)
                        begin
                            if (sts.last_entry)
                                state_next = snrt_pkg::S_IDLE;
                            else
                            begin
                                cmd.idx_op = snrt_pkg::IDX_INC;
                                state_next = snrt_pkg::S_WALK;
                            end
                        end
                    end
                    snrt_pkg::KIND_INSERT:
                    begin
                        if (sts.key_eq)
                        begin
                            cmd.out_load   = sts.out_free;
                            cmd.out_status = snrt_pkg::ST_DUPLICATE;
                            cmd.out_src    = snrt_pkg::SRC_REQ_HIT;
                            if (sts.out_free)
                                state_next = snrt_pkg::S_IDLE;
                        end
                        else if (sts.key_gt)
                        begin
                            if (sts.full)
                            begin
                                cmd.out_load   = sts.out_free;
                                cmd.out_status = snrt_pkg::ST_FULL;
                                if (sts.out_free)
                                    state_next = snrt_pkg::S_IDLE;
                            end
                            else
                            begin
                                // slot found; shift from the tail down to it
                                cmd.set_pos = 1'b1;
                                cmd.idx_op  = snrt_pkg::IDX_COUNT;
                                state_next  = snrt_pkg::S_ISHIFT;
                            end
                        end
                        else
                        begin
                            cmd.idx_op = snrt_pkg::IDX_INC;
                            state_next = snrt_pkg::S_WALK;
                        end
                    end
                    default:
                    begin
                        // delete and search; sorted order ends the walk early
                        if (sts.key_eq)
                        begin
                            cmd.out_load = sts.out_free;
                            cmd.out_src  = snrt_pkg::SRC_REQ_HIT;
                            if (sts.kind == snrt_pkg::KIND_DELETE)
                                cmd.out_status = snrt_pkg::ST_DELETED;
                            else
                                cmd.out_status = snrt_pkg::ST_FOUND;
                            if (sts.out_free)
                            begin
                                if (sts.kind == snrt_pkg::KIND_DELETE)
                                    state_next = snrt_pkg::S_DSHIFT;
                                else
                                    state_next = snrt_pkg::S_IDLE;
                            end
                        end
                        else if (sts.key_gt)
                        begin
                            cmd.out_load   = sts.out_free;
                            cmd.out_status = snrt_pkg::ST_MISSING;
                            if (sts.out_free)
                                state_next = snrt_pkg::S_IDLE;
                        end
                        else
                        begin
                            cmd.idx_op = snrt_pkg::IDX_INC;
                            state_next = snrt_pkg::S_WALK;
                        end
                    end
                endcase
            end

            snrt_pkg::S_ISHIFT:
            begin
                if (sts.idx_gt_pos)
                begin
                    cmd.mem_rd = 1'b1;
                    cmd.rd_sel = snrt_pkg::RD_PREV;
                    state_next = snrt_pkg::S_IWRITE;
                end
                else
                begin
                    cmd.wr_op  = snrt_pkg::WR_REQ;
                    cmd.cnt_op = snrt_pkg::CNT_INC;
                    cmd.out_load   = sts.out_free;
                    cmd.out_status = snrt_pkg::ST_INSERTED;
                    if (sts.out_free)
                        state_next = snrt_pkg::S_IDLE;
                    else
                    begin
                        // hold the write until the result can be posted
                        cmd.wr_op  = snrt_pkg::WR_NONE;
                        cmd.cnt_op = snrt_pkg::CNT_HOLD;
                    end
                end
            end

            snrt_pkg::S_IWRITE:
            begin
                cmd.wr_op  = snrt_pkg::WR_RD;
                cmd.idx_op = snrt_pkg::IDX_DEC;
                state_next = snrt_pkg::S_ISHIFT;
            end

            snrt_pkg::S_DSHIFT:
            begin
                if (sts.next_in)
                begin
                    cmd.mem_rd = 1'b1;
                    cmd.rd_sel = snrt_pkg::RD_NEXT;
                    state_next = snrt_pkg::S_DWRITE;
                end
                else
                begin
                    cmd.cnt_op = snrt_pkg::CNT_DEC;
                    state_next = snrt_pkg::S_IDLE;
                end
            end

            snrt_pkg::S_DWRITE:
            begin
                cmd.wr_op  = snrt_pkg::WR_RD;
                cmd.idx_op = snrt_pkg::IDX_INC;
                state_next = snrt_pkg::S_DSHIFT;
            end

            default: state_next = snrt_pkg::S_IDLE;
        endcase
    end

endmodule

### design/sorted_name_record_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_name_record_table
// Sorted table of name/phone records with insert, delete, search and dump.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request per transaction:
//   kind selects insert, delete, search or dump; the key is the 80-bit name
//   key_high:key_low; value fields are used by insert only.
//   Output channel (out_valid / out_stall) returns status, key, value and
//   last. Insert, delete and search give one result; dump gives one result
//   per stored record in ascending name order, last set on the final one,
//   or a single dump-empty result when the table holds nothing.
//   One request is worked at a time; in_stall is high until it is done.
//   A walk visits each record with a memory read, then a compare, and the
//   insert/delete shift moves each record with a read, then a write, over
//   the single read and single write port of the record memory. A result
//   sits in the output register while the next request is taken; a stalled
//   receiver holds the result and, once the next result is ready, holds the
//   controller in place.
//   Reset empties the table (record count to zero) and drops any pending
//   result. Record memory contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_name_record_table #(
    parameter int ENTRIES = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        kind,
    input  logic [snrt_pkg::KEY_HIGH_W-1:0]   key_high,
    input  logic [snrt_pkg::KEY_LOW_W-1:0]    key_low,
    input  logic [snrt_pkg::VALUE_HIGH_W-1:0] value_high,
    input  logic [snrt_pkg::VALUE_MID_W-1:0]  value_mid,
    input  logic [snrt_pkg::VALUE_LOW_W-1:0]  value_low,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [3:0]                        status,
    output logic [snrt_pkg::KEY_HIGH_W-1:0]   out_key_high,
    output logic [snrt_pkg::KEY_LOW_W-1:0]    out_key_low,
    output logic [snrt_pkg::VALUE_HIGH_W-1:0] out_value_high,
    output logic [snrt_pkg::VALUE_MID_W-1:0]  out_value_mid,
    output logic [snrt_pkg::VALUE_LOW_W-1:0]  out_value_low,
    output logic                              last
);

    snrt_pkg::dp_cmd_t cmd;
    snrt_pkg::dp_sts_t sts;

    // sequencer: one request in flight, steps the datapath per state
    snrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // record memory, index/count registers, key compare, output register
    snrt_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .kind           (kind),
        .key_high       (key_high),
        .key_low        (key_low),
        .value_high     (value_high),
        .value_mid      (value_mid),
        .value_low      (value_low),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .out_key_high   (out_key_high),
        .out_key_low    (out_key_low),
        .out_value_high (out_value_high),
        .out_value_mid  (out_value_mid),
        .out_value_low  (out_value_low),
        .last           (last)
    );

endmodule

### verif/tb_sorted_name_record_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_name_record_table
// Self-checking bench for the sorted name/phone record table. A scoreboard
// model tracks the ordered records. Every request accepted on the input
// channel queues the results it must cause. The output channel compares each
// result field by field with the oldest queued one. Stimulus is a short
// directed run through the corner cases and then a random mix of requests.
// Key choices keep hit rates high, and the mix swings between filling the
// table and emptying it.
// ----------------------------------------------------------------------------
module tb_sorted_name_record_table;

    localparam int ENTRIES      = 16;
    localparam int RANDOM_ITEMS = 400;
    localparam int BLOCK_LEN    = 40;   // random requests per insert/delete bias block
    localparam int POOL_SIZE    = 24;   // more names than entries, so full is reachable
    localparam int DRAIN_CYCLES = 4 * ENTRIES + 16;
    localparam int CYCLE_LIMIT  = 400000;

    // One request as queued for the driver; hold_for_drain makes the driver
    // wait until every outstanding result has been returned.
    typedef struct packed {
        snrt_pkg::kind_t kind;
        snrt_pkg::rec_t  rec;
        logic            hold_for_drain;
    } request_t;

    typedef struct packed {
        snrt_pkg::status_t status;
        snrt_pkg::rec_t    rec;
        logic              last;
    } answer_t;

    logic                              clk        = 1'b0;
    logic                              rst_n      = 1'b0;
    logic                              in_valid   = 1'b0;
    logic                              in_stall;
    logic [1:0]                        kind       = snrt_pkg::KIND_INSERT;
    logic [snrt_pkg::KEY_HIGH_W-1:0]   key_high   = '0;
    logic [snrt_pkg::KEY_LOW_W-1:0]    key_low    = '0;
    logic [snrt_pkg::VALUE_HIGH_W-1:0] value_high = '0;
    logic [snrt_pkg::VALUE_MID_W-1:0]  value_mid  = '0;
    logic [snrt_pkg::VALUE_LOW_W-1:0]  value_low  = '0;
    logic                              out_valid;
    logic                              out_stall  = 1'b0;
    logic [3:0]                        status;
    logic [snrt_pkg::KEY_HIGH_W-1:0]   out_key_high;
    logic [snrt_pkg::KEY_LOW_W-1:0]    out_key_low;
    logic [snrt_pkg::VALUE_HIGH_W-1:0] out_value_high;
    logic [snrt_pkg::VALUE_MID_W-1:0]  out_value_mid;
    logic [snrt_pkg::VALUE_LOW_W-1:0]  out_value_low;
    logic                              last;

    // Scoreboard copy of the table: records kept sorted, slots at and above
    // table_count are don't-care.
    snrt_pkg::rec_t table_rec [ENTRIES];
    int             table_count = 0;
    answer_t        answer_q [$];      // results still owed by the DUT, oldest first
    request_t       pending_q [$];     // requests not yet presented to the DUT
    request_t       on_bus;            // transaction currently driven on the input
    snrt_pkg::rec_t name_pool [POOL_SIZE];

    int errors       = 0;
    int accepted     = 0;
    int total_items  = 0;
    int results_seen = 0;
    int cycles       = 0;
    int status_hits [9];

    sorted_name_record_table #(
        .ENTRIES(ENTRIES)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .key_high      (key_high),
        .key_low       (key_low),
        .value_high    (value_high),
        .value_mid     (value_mid),
        .value_low     (value_low),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .out_key_high  (out_key_high),
        .out_key_low   (out_key_low),
        .out_value_high(out_value_high),
        .out_value_mid (out_value_mid),
        .out_value_low (out_value_low),
        .last          (last)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Scoreboard model
    // ------------------------------------------------------------------

    // Index of the record holding this name, or -1.
    function automatic int locate_name(input logic [snrt_pkg::KEY_W-1:0] name);
        int i;
        for (i = 0; i < table_count; i++)
        begin
            if ({table_rec[i].key_high, table_rec[i].key_low} == name)
                return i;
        end
        return -1;
    endfunction

    // Applies one accepted request to the model and queues its results.
    task automatic predict_table_results(input request_t req);
        logic [snrt_pkg::KEY_W-1:0] req_name;
        logic [snrt_pkg::KEY_W-1:0] row_name;
        int                         pos;
        int                         hit;
        int                         i;
        answer_t                    ans;
        begin
            req_name = {req.rec.key_high, req.rec.key_low};
            // Single results echo the request name; value is zero unless a
            // stored record was matched.
            ans.rec            = req.rec;
            ans.rec.value_high = '0;
            ans.rec.value_mid  = '0;
            ans.rec.value_low  = '0;
            ans.last           = 1'b1;
            case (req.kind)
                snrt_pkg::KIND_INSERT:
                begin
                    pos = table_count;
                    hit = -1;
                    for (i = 0; i < table_count; i++)
                    begin
                        row_name = {table_rec[i].key_high, table_rec[i].key_low};
                        if (row_name == req_name)
                        begin
                            hit = i;
                            break;
                        end
                        if (row_name > req_name)
                        begin
                            pos = i;
                            break;
                        end
                    end
                    // duplicate wins over full
                    if (hit >= 0)
                    begin
                        ans.status         = snrt_pkg::ST_DUPLICATE;
                        ans.rec.value_high = table_rec[hit].value_high;
                        ans.rec.value_mid  = table_rec[hit].value_mid;
                        ans.rec.value_low  = table_rec[hit].value_low;
                    end
                    else if (table_count >= ENTRIES)
                        ans.status = snrt_pkg::ST_FULL;
                    else
                    begin
                        for (i = table_count; i > pos; i--)
                            table_rec[i] = table_rec[i-1];
                        table_rec[pos] = req.rec;
                        table_count++;
                        ans.status = snrt_pkg::ST_INSERTED;
                    end
                    answer_q.push_back(ans);
                end
                snrt_pkg::KIND_DELETE, snrt_pkg::KIND_SEARCH:
                begin
                    hit = locate_name(req_name);
                    if (req.kind == snrt_pkg::KIND_DELETE && table_count == 0)
                        ans.status = snrt_pkg::ST_EMPTY;
                    else if (hit < 0)
                        ans.status = snrt_pkg::ST_MISSING;
                    else
                    begin
                        if (req.kind == snrt_pkg::KIND_DELETE)
                            ans.status = snrt_pkg::ST_DELETED;
                        else
                            ans.status = snrt_pkg::ST_FOUND;
                        ans.rec.value_high = table_rec[hit].value_high;
                        ans.rec.value_mid  = table_rec[hit].value_mid;
                        ans.rec.value_low  = table_rec[hit].value_low;
                        if (req.kind == snrt_pkg::KIND_DELETE)
                        begin
                            for (i = hit; i + 1 < table_count; i++)
                                table_rec[i] = table_rec[i+1];
                            table_count--;
                        end
                    end
                    answer_q.push_back(ans);
                end
                default:
                begin
                    if (table_count == 0)
                    begin
                        ans.status = snrt_pkg::ST_DUMP_EMPTY;
                        ans.rec    = '0;
                        answer_q.push_back(ans);
                    end
                    for (i = 0; i < table_count; i++)
                    begin
                        ans.status = snrt_pkg::ST_DUMP_ENTRY;
                        ans.rec    = table_rec[i];
                        ans.last   = (i + 1 == table_count);
                        answer_q.push_back(ans);
                    end
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Idle/stall profile: receiver-heavy stalls in the first third of the
    // requests, sender-heavy gaps in the second, none in the last third.
    // ------------------------------------------------------------------
    function automatic int idle_phase();
        if (accepted * 3 < total_items)
            return 0;
        if (accepted * 3 < total_items * 2)
            return 1;
        return 2;
    endfunction

    function automatic int sender_idle_pct();
        case (idle_phase())
            0:       return 17;
            1:       return 46;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case (idle_phase())
            0:       return 46;
            1:       return 17;
            default: return 0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: predicts on every accepted transaction, then presents the
    // next queued request unless it idles. A stalled payload stays put.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_table_results(on_bus);
                accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_q.size() != 0
                    && !(pending_q[0].hold_for_drain && answer_q.size() != 0)
                    && $urandom_range(0, 99) >= sender_idle_pct())
                begin
                    on_bus     = pending_q.pop_front();
                    in_valid   <= 1'b1;
                    kind       <= on_bus.kind;
                    key_high   <= on_bus.rec.key_high;
                    key_low    <= on_bus.rec.key_low;
                    value_high <= on_bus.rec.value_high;
                    value_mid  <= on_bus.rec.value_mid;
                    value_low  <= on_bus.rec.value_low;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random receiver stall, and a field-by-field compare of each
    // accepted result against the oldest owed result.
    // ------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [63:0] exp_v,
                                 input logic [63:0] got_v);
        if (exp_v !== got_v)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, got_v);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        answer_t owed;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            out_stall <= ($urandom_range(0, 99) < receiver_stall_pct());
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (answer_q.size() == 0)
                begin
                    $error("result with none owed: status %0d", status);
                    errors++;
                end
                else
                begin
                    owed = answer_q.pop_front();
                    status_hits[owed.status]++;
                    compare_field("status", owed.status, status);
                    compare_field("out_key_high", owed.rec.key_high, out_key_high);
                    compare_field("out_key_low", owed.rec.key_low, out_key_low);
                    compare_field("out_value_high", owed.rec.value_high, out_value_high);
                    compare_field("out_value_mid", owed.rec.value_mid, out_value_mid);
                    compare_field("out_value_low", owed.rec.value_low, out_value_low);
                    compare_field("last", owed.last, last);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_request(input snrt_pkg::kind_t k, input snrt_pkg::rec_t rec,
                                 input logic hold);
        request_t req;
        begin
            req.kind           = k;
            req.rec            = rec;
            req.hold_for_drain = hold;
            pending_q.push_back(req);
        end
    endtask

    // Pool name with a fresh random phone number.
    function automatic snrt_pkg::rec_t named_record(input int idx);
        snrt_pkg::rec_t rec;
        rec            = name_pool[idx];
        rec.value_high = $urandom;
        rec.value_mid  = {$urandom, $urandom};
        rec.value_low  = {$urandom, $urandom};
        return rec;
    endfunction

    initial
    begin
        snrt_pkg::rec_t  rec;
        snrt_pkg::kind_t k;
        int              i;
        int              roll;
        bit              fill_bias;

        // Name pool: all-zero, all-ones, a one-letter name, the same name
        // with junk after the terminator, a shared two-byte prefix group and
        // fully random names.
        name_pool[0] = '0;
        name_pool[1] = '0;
        name_pool[1].key_high = '1;
        name_pool[1].key_low  = '1;
        name_pool[2] = '0;
        name_pool[2].key_high = 16'h4100;
        name_pool[3] = name_pool[2];
        name_pool[3].key_low  = 64'h0000_0000_0000_0001;
        name_pool[4] = '0;
        name_pool[4].key_high = 16'h4142;
        name_pool[4].key_low  = 64'h4300_0000_0000_0000;
        for (i = 5; i < POOL_SIZE; i++)
        begin
            name_pool[i] = '0;
            name_pool[i].key_high = (i % 2) ? 16'h4142 : 16'($urandom);
            name_pool[i].key_low  = {$urandom, $urandom};
        end

        // Directed: empty-table cases, boundary names, duplicate, hits and
        // misses, then fill to capacity and probe full vs. duplicate.
        queue_request(snrt_pkg::KIND_DUMP, '0, 1'b0);
        queue_request(snrt_pkg::KIND_DELETE, named_record(4), 1'b0);
        queue_request(snrt_pkg::KIND_INSERT, named_record(4), 1'b0);
        queue_request(snrt_pkg::KIND_INSERT, named_record(0), 1'b0);
        queue_request(snrt_pkg::KIND_INSERT, named_record(1), 1'b0);
        queue_request(snrt_pkg::KIND_INSERT, named_record(2), 1'b0);
        queue_request(snrt_pkg::KIND_INSERT, named_record(3), 1'b0);
        queue_request(snrt_pkg::KIND_INSERT, named_record(2), 1'b0);
        queue_request(snrt_pkg::KIND_SEARCH, named_record(3), 1'b0);
        queue_request(snrt_pkg::KIND_SEARCH, named_record(7), 1'b0);
        queue_request(snrt_pkg::KIND_DELETE, named_record(7), 1'b0);
        queue_request(snrt_pkg::KIND_DELETE, named_record(1), 1'b0);
        for (i = 5; i < 17; i++)
            queue_request(snrt_pkg::KIND_INSERT, named_record(i), 1'b0);
        queue_request(snrt_pkg::KIND_INSERT, named_record(17), 1'b0);
        queue_request(snrt_pkg::KIND_INSERT, named_record(0), 1'b0);
        queue_request(snrt_pkg::KIND_DUMP, '0, 1'b0);

        // Random: blocks alternate between insert-heavy and delete-heavy so
        // the table swings between full and empty. Mostly pool names for
        // hits, some fully random names for misses.
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            fill_bias = ((i / BLOCK_LEN) % 2) == 0;
            roll = $urandom_range(0, 99);
            if (roll < 10)
                k = snrt_pkg::KIND_DUMP;
            else if (roll < 30)
                k = snrt_pkg::KIND_SEARCH;
            else if (roll < (fill_bias ? 45 : 85))
                k = snrt_pkg::KIND_DELETE;
            else
                k = snrt_pkg::KIND_INSERT;
            rec = named_record($urandom_range(0, POOL_SIZE - 1));
            if ($urandom_range(0, 99) < 15)
            begin
                rec.key_high = 16'($urandom);
                rec.key_low  = {$urandom, $urandom};
            end
            // dump ignores the payload, but keep it random anyway
            queue_request(k, rec, (i % 100) == 0);
        end
        total_items = pending_q.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || in_valid)
            @(posedge clk);
        while (answer_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run summary: %0d requests, %0d results compared", accepted, results_seen);
        $display("  inserted %0d, duplicate %0d, full %0d, deleted %0d, empty %0d, dump rows %0d",
                 status_hits[snrt_pkg::ST_INSERTED], status_hits[snrt_pkg::ST_DUPLICATE],
                 status_hits[snrt_pkg::ST_FULL], status_hits[snrt_pkg::ST_DELETED],
                 status_hits[snrt_pkg::ST_EMPTY], status_hits[snrt_pkg::ST_DUMP_ENTRY]);
        if (errors == 0 && answer_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
